[sv/dxtd_pkg.sv]
// ----------------------------------------------------------------------------
// dxtd_pkg
// Shared types, format codes and arithmetic helpers for the dxt block decoder.
// ----------------------------------------------------------------------------
package dxtd_pkg;

	// block format codes, code 3 decodes as dxt1
	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int PIXELS = 16;

	// reciprocal constants for division by small constants
	localparam logic [9:0]  RECIP3 = 10'd683;    // x/3 = x*683 >> 11, x < 2048
	localparam logic [13:0] RECIP7 = 14'd9363;   // x/7 = x*9363 >> 16, x < 13107
	localparam logic [13:0] RECIP5 = 14'd13108;  // x/5 = x*13108 >> 16, x < 16384

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	// one decoded block waiting for the back part
	typedef struct packed {
		rgb_t [3:0]       pal;
		logic             four;
		logic [7:0][7:0]  atab;
		logic [31:0]      cidx;
		logic [63:0]      ahalf;
	} entry_t;

	// rgb565 to rgb888 by bit replication
	function automatic rgb_t expand565(input logic [15:0] c);
		rgb_t o;
		o.r = {c[15:11], c[15:13]};
		o.g = {c[10:5], c[10:9]};
		o.b = {c[4:0], c[4:2]};
		return o;
	endfunction

	function automatic chan_t div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'(RECIP3);
		return p[18:11];
	endfunction

	function automatic chan_t div7(input logic [10:0] x);
		logic [24:0] p;
		p = 25'(x) * 25'(RECIP7);
		return p[23:16];
	endfunction

	function automatic chan_t div5(input logic [10:0] x);
		logic [24:0] p;
		p = 25'(x) * 25'(RECIP5);
		return p[23:16];
	endfunction

endpackage

[sv/dxt_block_decoder.sv]
// ----------------------------------------------------------------------------
// dxt_block_decoder
// Decodes one dxt1, dxt3 or dxt5 compressed 4x4 block into sixteen rgba8
// pixels in row-major order.
// ----------------------------------------------------------------------------
// A block request is taken when start is high and busy is low. Its sixteen
// pixels come out on consecutive cycles, each for one cycle with pixel_valid
// high, and the receiver cannot stall them. On the way out a block passes
// the input register, the stage two registers, the queue and the result
// registers. The back part sends one pixel per cycle while the queue holds a
// block.
// A two-stage front part and a queue of QUEUE_DEPTH decoded blocks let new
// requests in while a block is being sent; busy rises only once both front
// stages and the queue are occupied. block_format may only be written while
// no block is in flight.
module dxt_block_decoder #(
	parameter int QUEUE_DEPTH = dxtd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] alpha_half,
	input  logic [63:0] color_half,
	output logic        pixel_valid,
	output logic [3:0]  pixel_number,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  opacity,
	output logic        last_pixel
);
	import dxtd_pkg::*;

	logic [1:0] format_q;
	logic       push, full, pop, head_valid;
	entry_t     push_data, head;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_DXT1;
		end else if (cfg_write) begin
			format_q <= cfg_data;
		end
	end

	dxtd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.alpha_half (alpha_half),
		.color_half (color_half),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	dxtd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dxtd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.block_format (format_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.pixel_valid  (pixel_valid),
		.pixel_number (pixel_number),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.opacity      (opacity),
		.last_pixel   (last_pixel)
	);

`ifndef SYNTHESIS
	// a block, once started, is sent without gaps and in order
	a_pixel_run: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !last_pixel |=>
			pixel_valid && (pixel_number == $past(pixel_number) + 4'd1))
		else $error("pixel run broken inside a block");

	// a new block always begins at pixel zero
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && last_pixel |=> !pixel_valid || (pixel_number == 4'd0))
		else $error("block did not start at pixel zero");

	// the queue never takes a push while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");
`endif

endmodule

[sv/dxtd_front.sv]
// ----------------------------------------------------------------------------
// dxtd_front
// Accepts compressed blocks, classifies colour and alpha modes and builds the
// palette and alpha table over two stages before pushing into the queue.
// ----------------------------------------------------------------------------
module dxtd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [63:0]          alpha_half,
	input  logic [63:0]          color_half,
	output logic                 push,
	output dxtd_pkg::entry_t     push_data,
	input  logic                 full
);
	import dxtd_pkg::*;

	logic        v1_q, v2_q;
	logic [63:0] ahalf_s1, chalf_s1;

	logic        s1_free, s2_free;

	// stage one decode
	logic [15:0] c0, c1;
	logic        four;
	rgb_t        e0, e1;
	logic [7:0]  a0, a1;
	logic        agt;
	logic [2:0][9:0] n2, n3;
	logic [7:2][10:0] an;

	// stage two registers
	rgb_t        e0_s2, e1_s2;
	logic [2:0][9:0] n2_s2, n3_s2;
	logic        four_s2, agt_s2;
	logic [7:2][10:0] an_s2;
	logic [31:0] cidx_s2;
	logic [63:0] ahalf_s2;

	// flow control
	assign s2_free = !v2_q || !full;
	assign s1_free = !v1_q || s2_free;
	assign busy    = !s1_free;
	assign push    = v2_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (s1_free) v1_q <= start;
			if (s2_free) v2_q <= v1_q;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (start && s1_free) begin
			ahalf_s1 <= alpha_half;
			chalf_s1 <= color_half;
		end
	end

	// endpoint expansion and mode classification
	always_comb begin
		c0   = chalf_s1[15:0];
		c1   = chalf_s1[31:16];
		four = c0 > c1;
		e0   = expand565(c0);
		e1   = expand565(c1);
		a0   = ahalf_s1[7:0];
		a1   = ahalf_s1[15:8];
		agt  = a0 > a1;
	end

	// colour numerators, weighted thirds or a plain sum
	always_comb begin
		logic [2:0][7:0] x0, x1;
		x0 = {e0.r, e0.g, e0.b};
		x1 = {e1.r, e1.g, e1.b};
		for (int ch = 0; ch < 3; ch++) begin
			if (four) begin
				n2[ch] = {x0[ch], 1'b0} + 10'(x1[ch]);
				n3[ch] = 10'(x0[ch]) + {x1[ch], 1'b0};
			end else begin
				n2[ch] = 10'(x0[ch]) + 10'(x1[ch]);
				n3[ch] = '0;
			end
		end
	end

	// alpha numerators for the interpolated entries
	always_comb begin
		for (int i = 2; i < 8; i++) begin
			if (agt)
				an[i] = 11'(a0) * 11'(8 - i) + 11'(a1) * 11'(i - 1);
			else if (i < 6)
				an[i] = 11'(a0) * 11'(6 - i) + 11'(a1) * 11'(i - 1);
			else
				an[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q && s2_free) begin
			e0_s2    <= e0;
			e1_s2    <= e1;
			n2_s2    <= n2;
			n3_s2    <= n3;
			four_s2  <= four;
			agt_s2   <= agt;
			an_s2    <= an;
			cidx_s2  <= chalf_s1[63:32];
			ahalf_s2 <= ahalf_s1;
		end
	end

	// divisions by reciprocal, or halving in three-colour mode, result lands in the queue
	always_comb begin
		rgb_t p2, p3;
		p2.r = four_s2 ? div3(n2_s2[2]) : n2_s2[2][8:1];
		p2.g = four_s2 ? div3(n2_s2[1]) : n2_s2[1][8:1];
		p2.b = four_s2 ? div3(n2_s2[0]) : n2_s2[0][8:1];
		p3.r = four_s2 ? div3(n3_s2[2]) : '0;
		p3.g = four_s2 ? div3(n3_s2[1]) : '0;
		p3.b = four_s2 ? div3(n3_s2[0]) : '0;
		push_data.pal   = {p3, p2, e1_s2, e0_s2};
		push_data.four  = four_s2;
		push_data.cidx  = cidx_s2;
		push_data.ahalf = ahalf_s2;
		push_data.atab[0] = ahalf_s2[7:0];
		push_data.atab[1] = ahalf_s2[15:8];
		for (int i = 2; i < 8; i++) begin
			if (agt_s2)
				push_data.atab[i] = div7(an_s2[i]);
			else if (i < 6)
				push_data.atab[i] = div5(an_s2[i]);
			else if (i == 6)
				push_data.atab[i] = 8'd0;
			else
				push_data.atab[i] = 8'd255;
		end
	end

endmodule

[sv/dxtd_queue.sv]
// ----------------------------------------------------------------------------
// dxtd_queue
// Short queue of decoded blocks between the front and the back part.
// ----------------------------------------------------------------------------
module dxtd_queue #(
	parameter int DEPTH = dxtd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dxtd_pkg::entry_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output dxtd_pkg::entry_t  head
);
	import dxtd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wrap_inc(wr_q);
			if (pop)  rd_q <= wrap_inc(rd_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[sv/dxtd_back.sv]
// ----------------------------------------------------------------------------
// dxtd_back
// Walks the head block of the queue, one pixel per cycle, into the result
// registers.
// ----------------------------------------------------------------------------
module dxtd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        block_format,
	input  logic              head_valid,
	input  dxtd_pkg::entry_t  head,
	output logic              pop,
	output logic              pixel_valid,
	output logic [3:0]        pixel_number,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [7:0]        opacity,
	output logic              last_pixel
);
	import dxtd_pkg::*;

	logic [3:0] cnt_q;
	logic       valid_q;
	logic [3:0] num_q;
	rgb_t       rgb_q;
	chan_t      alpha_q;

	logic [1:0] ci;
	logic [3:0] nib;
	logic [2:0] ai;
	logic [6:0] ai_pos;
	rgb_t       rgb;
	chan_t      alpha;

	assign pop = head_valid && (cnt_q == 4'(PIXELS - 1));

	// per pixel selection
	always_comb begin
		ci     = head.cidx[{cnt_q, 1'b0} +: 2];
		nib    = head.ahalf[{cnt_q, 2'b00} +: 4];
		ai_pos = 7'd16 + 7'(cnt_q) * 7'd3;
		ai     = head.ahalf[ai_pos[5:0] +: 3];
		rgb    = head.pal[ci];
		unique case (block_format)
			FMT_DXT3: alpha = {nib, nib};
			FMT_DXT5: alpha = head.atab[ai];
			default:  alpha = (ci == 2'd3 && !head.four) ? 8'd0 : 8'd255;
		endcase
	end

	// pixel counter and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= head_valid;
			if (head_valid) cnt_q <= cnt_q + 1'b1;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (head_valid) begin
			num_q   <= cnt_q;
			rgb_q   <= rgb;
			alpha_q <= alpha;
		end
	end

	assign pixel_valid  = valid_q;
	assign pixel_number = num_q;
	assign red          = rgb_q.r;
	assign green        = rgb_q.g;
	assign blue         = rgb_q.b;
	assign opacity      = alpha_q;
	assign last_pixel   = num_q == 4'(PIXELS - 1);

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Block-level test of dxt_block_decoder. Compressed blocks are pushed in
// through the start/busy handshake under every block format, and each block
// is decoded here in parallel to sixteen expected pixels; every pixel strobed
// out is checked field by field against the oldest one still pending.
// ----------------------------------------------------------------------------
module tb;
	import dxtd_pkg::*;

	// format code with no scheme of its own, decodes as dxt1
	localparam logic [1:0] FMT_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASE_ITEMS = 45;

	typedef struct packed {
		logic [3:0] num;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] alpha_half = '0;
	logic [63:0] color_half = '0;
	logic        pixel_valid;
	logic [3:0]  pixel_number;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  opacity;
	logic        last_pixel;

	pixel_t      pending_pixels[$];
	pixel_t      want;
	logic [1:0]  format_shadow = FMT_DXT1;
	int          errors = 0;
	int          cycles = 0;

	dxt_block_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.alpha_half   (alpha_half),
		.color_half   (color_half),
		.pixel_valid  (pixel_valid),
		.pixel_number (pixel_number),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.opacity      (opacity),
		.last_pixel   (last_pixel)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[dxt_block_decoder] ERROR");
			$finish;
		end
	end

	// decode one block into its sixteen expected pixels
	function automatic void decode_block(input logic [63:0] ah, input logic [63:0] ch);
		logic [15:0] c0;
		logic [15:0] c1;
		logic        four_colour;
		int          ep0[3];
		int          ep1[3];
		int          pal[4][3];
		int          pal_alpha[4];
		int          atab[8];
		int          a0;
		int          a1;
		int          ci;
		int          ai;
		pixel_t      px;
		c0 = ch[15:0];
		c1 = ch[31:16];
		four_colour = c0 > c1;
		// rgb565 endpoints widened by bit replication
		ep0[0] = int'({c0[15:11], c0[15:13]});
		ep0[1] = int'({c0[10:5], c0[10:9]});
		ep0[2] = int'({c0[4:0], c0[4:2]});
		ep1[0] = int'({c1[15:11], c1[15:13]});
		ep1[1] = int'({c1[10:5], c1[10:9]});
		ep1[2] = int'({c1[4:0], c1[4:2]});
		// colour palette, thirds or half plus transparent black
		for (int k = 0; k < 3; k++) begin
			pal[0][k] = ep0[k];
			pal[1][k] = ep1[k];
			if (four_colour) begin
				pal[2][k] = (2 * ep0[k] + ep1[k]) / 3;
				pal[3][k] = (ep0[k] + 2 * ep1[k]) / 3;
			end else begin
				pal[2][k] = (ep0[k] + ep1[k]) / 2;
				pal[3][k] = 0;
			end
		end
		pal_alpha[0] = 255;
		pal_alpha[1] = 255;
		pal_alpha[2] = 255;
		pal_alpha[3] = four_colour ? 255 : 0;
		// interpolated alpha, eight-step or six-step with fixed ends
		a0 = int'(ah[7:0]);
		a1 = int'(ah[15:8]);
		atab[0] = a0;
		atab[1] = a1;
		if (a0 > a1) begin
			for (int i = 2; i < 8; i++)
				atab[i] = ((8 - i) * a0 + (i - 1) * a1) / 7;
		end else begin
			for (int i = 2; i < 6; i++)
				atab[i] = ((6 - i) * a0 + (i - 1) * a1) / 5;
			atab[6] = 0;
			atab[7] = 255;
		end
		for (int p = 0; p < 16; p++) begin
			ci = int'(ch[32 + 2 * p +: 2]);
			ai = int'(ah[16 + 3 * p +: 3]);
			px.num = p[3:0];
			px.r = pal[ci][0][7:0];
			px.g = pal[ci][1][7:0];
			px.b = pal[ci][2][7:0];
			if (format_shadow == FMT_DXT3)
				px.a = 8'(ah[4 * p +: 4]) * 8'd17;
			else if (format_shadow == FMT_DXT5)
				px.a = atab[ai][7:0];
			else
				px.a = pal_alpha[ci][7:0];
			px.last = (p == 15);
			pending_pixels.push_back(px);
		end
	endfunction

	function automatic void check_field(input string label, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, label, exp_v, got_v);
			errors++;
		end
	endfunction

	// pixel checker, the receiver never stalls
	always @(posedge clk) begin
		if (arst_n && pixel_valid) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel %0d with no block pending, expected none, got %0d/%0d/%0d/%0d",
					$time, pixel_number, red, green, blue, opacity);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_number", int'(want.num), int'(pixel_number));
				check_field("red", int'(want.r), int'(red));
				check_field("green", int'(want.g), int'(green));
				check_field("blue", int'(want.b), int'(blue));
				check_field("opacity", int'(want.a), int'(opacity));
				check_field("last_pixel", int'(want.last), int'(last_pixel));
			end
		end
	end

	// one block request, start is left high for a following request
	task automatic send_block(input logic [63:0] ah, input logic [63:0] ch);
		@(negedge clk);
		start = 1'b1;
		alpha_half = ah;
		color_half = ch;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		decode_block(ah, ch);
	endtask

	// sender gap with junk on the data lines
	task automatic sender_gap(input int n);
		@(negedge clk);
		start = 1'b0;
		alpha_half = {$urandom, $urandom};
		color_half = {$urandom, $urandom};
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_format(input logic [1:0] fmt);
		wait_drained();
		cfg_write = 1'b1;
		cfg_data = fmt;
		@(negedge clk);
		cfg_write = 1'b0;
		cfg_data = 2'($urandom);
		format_shadow = fmt;
	endtask

	task automatic random_block(output logic [63:0] ah, output logic [63:0] ch);
		logic [15:0] c0;
		logic [15:0] c1;
		c0 = 16'($urandom);
		c1 = 16'($urandom);
		ah = {$urandom, $urandom};
		// bias towards equal and extreme endpoints and alpha pairs
		case ($urandom_range(0, 7))
			0: c1 = c0;
			1: c0 = 16'hFFFF;
			2: c1 = 16'h0000;
			3: ah[15:8] = ah[7:0];
			default: ;
		endcase
		ch = {$urandom, c1, c0};
	endtask

	task automatic test_dxt1_colour_modes();
		set_format(FMT_DXT1);
		// four colours, every index
		send_block({$urandom, $urandom}, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
		// equal endpoints fall into three-colour mode
		send_block({$urandom, $urandom}, {32'hE4E4_E4E4, 16'h1234, 16'h1234});
		// three colours plus transparent black
		send_block({$urandom, $urandom}, {32'h1B1B_1B1B, 16'hFFFF, 16'h0000});
		send_block(64'hFFFF_FFFF_FFFF_FFFF, {32'hFFFF_FFFF, 16'hF81F, 16'h07E0});
		send_block(64'h0, 64'h0);
	endtask

	task automatic test_unused_format();
		logic [63:0] ah;
		logic [63:0] ch;
		set_format(FMT_UNUSED);
		send_block(64'hFFFF_FFFF_FFFF_FFFF, {32'hE4E4_E4E4, 16'h8410, 16'h7BEF});
		random_block(ah, ch);
		send_block(ah, ch);
	endtask

	task automatic test_dxt3_explicit_alpha();
		set_format(FMT_DXT3);
		send_block(64'h0123_4567_89AB_CDEF, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
		send_block(64'hFFFF_FFFF_FFFF_FFFF, {32'hFFFF_FFFF, 16'hFFFF, 16'h0000});
		send_block(64'h0, {32'hE4E4_E4E4, 16'hABCD, 16'hABCD});
		send_block(64'hFEDC_BA98_7654_3210, {32'h0000_0000, 16'h0001, 16'hFFFE});
	endtask

	task automatic test_dxt5_interpolated_alpha();
		logic [47:0] ramp;
		for (int p = 0; p < 16; p++)
			ramp[3 * p +: 3] = p[2:0];
		set_format(FMT_DXT5);
		// eight-step table, every index
		send_block({ramp, 8'h00, 8'hFF}, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
		// six-step table with fixed ends
		send_block({ramp, 8'hFF, 8'h00}, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
		send_block({ramp, 8'h5A, 8'h5A}, {32'h1B1B_1B1B, 16'h2222, 16'h3333});
		send_block({48'hFFFF_FFFF_FFFF, 8'h01, 8'hFE}, {32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE});
		send_block({48'h0, 8'hFF, 8'hFF}, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// random blocks in phases, sender gaps in all but the last phase
	task automatic test_random_blocks();
		logic [1:0]  phase_fmt[4];
		logic [63:0] ah;
		logic [63:0] ch;
		bit          gaps_on;
		phase_fmt[0] = FMT_DXT5;
		phase_fmt[1] = FMT_DXT1;
		phase_fmt[2] = FMT_DXT3;
		phase_fmt[3] = FMT_DXT5;
		for (int ph = 0; ph < 4; ph++) begin
			set_format(phase_fmt[ph]);
			gaps_on = 1'b1;
			for (int n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
				if (n % 10 == 0)
					gaps_on = (ph != 3) && ($urandom_range(0, 3) != 0);
				if (gaps_on && $urandom_range(0, 2) == 0)
					sender_gap($urandom_range(1, 19));
				random_block(ah, ch);
				send_block(ah, ch);
			end
		end
	endtask

	// test sequence
	initial begin
		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;
		test_dxt1_colour_modes();
		test_unused_format();
		test_dxt3_explicit_alpha();
		test_dxt5_interpolated_alpha();
		test_random_blocks();
		wait_drained();
		if (errors == 0)
			$display("[dxt_block_decoder] OK");
		else
			$display("[dxt_block_decoder] ERROR");
		$finish;
	end

endmodule
